// ===== sv/phd_pkg.sv =====
// Shared types and constants for the packet header hash distributor.
// Used by the byte parser, the modulo unit and the top level; no dependencies.
`timescale 1ns / 1ps

package phd_pkg;

  // Frame and protocol constants.
  localparam int unsigned MAX_VLAN_TAGS = 4;
  localparam int unsigned MAX_DESTS     = 32;
  localparam int unsigned HASH_W        = 32;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned SLV_W         = 6;
  localparam int unsigned CNT_W         = 5;

  localparam logic [15:0] ETH_VLAN     = 16'h8100;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ETH_IPV6     = 16'h86DD;
  localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
  localparam logic [15:0] IPV4_HDR_LEN = 16'd20;
  localparam logic [15:0] IPV6_HDR_LEN = 16'd40;

  // Configuration register indexes.
  localparam logic CFG_HASH_MODE  = 1'b0;
  localparam logic CFG_DEST_COUNT = 1'b1;

  // Hash modes.
  typedef enum logic [1:0] {
    MODE_IP     = 2'd0,
    MODE_MAC    = 2'd1,
    MODE_PROTO  = 2'd2,
    MODE_FANOUT = 2'd3
  } phd_mode_e;

  // Modulo unit states.
  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_DONE
  } phd_mod_state_e;

  // Finished frame handed from the parser to the modulo unit.
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [SLV_W-1:0]  slaves;
    logic              fanout;
  } phd_frame_t;

  // Result handed from the modulo unit to the output register.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  idx;
    logic [HASH_W-1:0] mask;
  } phd_result_t;

endpackage

// ===== sv/phd_parser.sv =====
// Byte-wise frame parser: VLAN skipping, address and protocol gathering, hash sum.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  input  phd_pkg::phd_mode_e       mode_i,
  input  logic [phd_pkg::SLV_W-1:0] dest_count_i,
  output phd_pkg::phd_frame_t      frame_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] kind_q, kind_d;
  logic [7:0]  l3_q, l3_d;
  logic [2:0]  tags_q, tags_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] gather_q, gather_d;
  logic [7:0]  proto_q, proto_d;

  logic [16:0] pos_ext;
  logic [16:0] l3_ext;
  logic [15:0] off;
  logic [15:0] kind_lo;
  logic [31:0] word_new;
  logic        word_done;
  logic        mac_hit;
  logic [31:0] addend;
  logic [15:0] need;
  logic        len_ok;
  logic [31:0] final_hash;

  // Next header state for the byte on the input.
  always_comb begin
    pos_ext   = {1'b0, pos_q};
    l3_ext    = {9'd0, l3_q};
    off       = pos_q - {8'd0, l3_q};
    kind_lo   = {kind_q[15:8], data_byte_i};
    kind_d    = kind_q;
    l3_d      = l3_q;
    tags_d    = tags_q;
    gather_d  = gather_q;
    proto_d   = proto_q;
    word_new  = gather_q;
    word_done = 1'b0;

    if (pos_ext + 17'd2 == l3_ext) begin
      kind_d = {data_byte_i, 8'h00};
    end else if (pos_ext + 17'd1 == l3_ext) begin
      kind_d = kind_lo;
      if (kind_lo == phd_pkg::ETH_VLAN && tags_q < 3'(phd_pkg::MAX_VLAN_TAGS)) begin
        tags_d = tags_q + 3'd1;
        l3_d   = l3_q + 8'd4;
      end
    end else if (pos_q >= {8'd0, l3_q}) begin
      if (kind_q == phd_pkg::ETH_IPV4) begin
        if (off == 16'd9) proto_d = data_byte_i;
        if (off >= 16'd12 && off < 16'd20) begin
          // Big-endian word: shift earlier bytes up.
          word_new  = (off[1:0] == 2'd0) ? {24'd0, data_byte_i}
                                         : {gather_q[23:0], data_byte_i};
          word_done = (off[1:0] == 2'd3);
          gather_d  = word_done ? 32'd0 : word_new;
        end
      end else if (kind_q == phd_pkg::ETH_IPV6) begin
        if (off == 16'd6) proto_d = data_byte_i;
        if (off >= 16'd8 && off < 16'd40) begin
          // Little-endian word: each byte lands above the earlier ones.
          word_new  = (off[1:0] == 2'd0) ? {24'd0, data_byte_i}
                    : (gather_q | ({24'd0, data_byte_i} << {off[1:0], 3'b000}));
          word_done = (off[1:0] == 2'd3);
          gather_d  = word_done ? 32'd0 : word_new;
        end
      end
    end
  end

  // Single adder shared by the MAC byte sum and the address word sum.
  always_comb begin
    mac_hit = (mode_i == phd_pkg::MODE_MAC) &&
              ((pos_q >= 16'd3 && pos_q <= 16'd5) || (pos_q >= 16'd9 && pos_q <= 16'd11));
    if (mac_hit) begin
      addend = {24'd0, data_byte_i};
    end else if (word_done && mode_i == phd_pkg::MODE_IP) begin
      addend = word_new;
    end else begin
      addend = 32'd0;
    end
    accum_d = accum_q + addend;
    pos_d   = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
  end

  // Frame hash as seen after the last byte has been taken.
  always_comb begin
    if (kind_d == phd_pkg::ETH_IPV6) begin
      need = {8'd0, l3_d} + phd_pkg::IPV6_HDR_LEN;
    end else begin
      need = {8'd0, l3_d} + phd_pkg::IPV4_HDR_LEN;
    end
    len_ok = (pos_d >= need) &&
             (kind_d == phd_pkg::ETH_IPV4 || kind_d == phd_pkg::ETH_IPV6);
    unique case (mode_i)
      phd_pkg::MODE_MAC:    final_hash = accum_d;
      phd_pkg::MODE_IP:     final_hash = len_ok ? accum_d : 32'd0;
      phd_pkg::MODE_PROTO:  final_hash = len_ok ? {24'd0, proto_d} : 32'd0;
      phd_pkg::MODE_FANOUT: final_hash = 32'd0;
      default:              final_hash = 32'd0;
    endcase
  end

  // Finished frame description, with the destination count clamped.
  always_comb begin
    frame_o.valid  = accept_i && last_byte_i;
    frame_o.hash   = final_hash;
    frame_o.fanout = (mode_i == phd_pkg::MODE_FANOUT);
    if (dest_count_i == '0) begin
      frame_o.slaves = phd_pkg::SLV_W'(1);
    end else if (dest_count_i > phd_pkg::SLV_W'(phd_pkg::MAX_DESTS)) begin
      frame_o.slaves = phd_pkg::SLV_W'(phd_pkg::MAX_DESTS);
    end else begin
      frame_o.slaves = dest_count_i;
    end
  end

  // Header state registers; cleared after each last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= '0;
      l3_q     <= phd_pkg::ETH_HDR_LEN;
      tags_q   <= '0;
      accum_q  <= '0;
      gather_q <= '0;
      proto_q  <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q    <= '0;
        kind_q   <= '0;
        l3_q     <= phd_pkg::ETH_HDR_LEN;
        tags_q   <= '0;
        accum_q  <= '0;
        gather_q <= '0;
        proto_q  <= '0;
      end else begin
        pos_q    <= pos_d;
        kind_q   <= kind_d;
        l3_q     <= l3_d;
        tags_q   <= tags_d;
        accum_q  <= accum_d;
        gather_q <= gather_d;
        proto_q  <= proto_d;
      end
    end
  end

endmodule

// ===== sv/phd_mod_unit.sv =====
// Iterative restoring modulo unit: hash mod destination count, one bit a cycle.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_mod_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phd_pkg::phd_frame_t  frame_i,
  input  logic                 release_i,
  output logic                 busy_o,
  output logic                 done_o,
  output phd_pkg::phd_result_t result_o
);

  phd_pkg::phd_mod_state_e state_q, state_d;

  logic [phd_pkg::HASH_W-1:0] hash_q;
  logic [phd_pkg::HASH_W-1:0] div_q;
  logic [phd_pkg::IDX_W-1:0]  rem_q;
  logic [phd_pkg::SLV_W-1:0]  n_q;
  logic                       fanout_q;
  logic [phd_pkg::CNT_W-1:0]  cnt_q;

  logic [phd_pkg::SLV_W-1:0]  trial;
  logic                       fits;
  logic                       last_step;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial     = {rem_q, div_q[phd_pkg::HASH_W-1]};
    fits      = (trial >= n_q);
    last_step = (cnt_q == phd_pkg::CNT_W'(phd_pkg::HASH_W - 1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      phd_pkg::MOD_IDLE: if (frame_i.valid) state_d = phd_pkg::MOD_RUN;
      phd_pkg::MOD_RUN:  if (last_step) state_d = phd_pkg::MOD_DONE;
      phd_pkg::MOD_DONE: if (release_i) state_d = phd_pkg::MOD_IDLE;
      default:           state_d = phd_pkg::MOD_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o          = (state_q != phd_pkg::MOD_IDLE);
    done_o          = (state_q == phd_pkg::MOD_DONE);
    result_o.hash   = hash_q;
    result_o.idx    = rem_q;
    if (fanout_q) begin
      result_o.mask = ~({phd_pkg::HASH_W{1'b1}} << n_q);
    end else begin
      result_o.mask = phd_pkg::HASH_W'(1) << rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phd_pkg::MOD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == phd_pkg::MOD_RUN) begin
        cnt_q <= cnt_q + phd_pkg::CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Datapath registers: load on a new frame, iterate while running.
  always_ff @(posedge clk_i) begin
    if (state_q == phd_pkg::MOD_IDLE && frame_i.valid) begin
      hash_q   <= frame_i.hash;
      div_q    <= frame_i.hash;
      rem_q    <= '0;
      n_q      <= frame_i.slaves;
      fanout_q <= frame_i.fanout;
    end else if (state_q == phd_pkg::MOD_RUN) begin
      div_q <= {div_q[phd_pkg::HASH_W-2:0], 1'b0};
      rem_q <= fits ? phd_pkg::IDX_W'(trial - n_q) : phd_pkg::IDX_W'(trial);
    end
  end

  // The remainder stays below the divisor throughout the iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != phd_pkg::MOD_IDLE) |-> ({1'b0, rem_q} < n_q))
    else $error("phd_mod_unit: remainder not below divisor");

  // A new frame only arrives while the unit is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid |-> (state_q == phd_pkg::MOD_IDLE))
    else $error("phd_mod_unit: frame arrived while busy");

  // The last step leads to the finished state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == phd_pkg::MOD_RUN && last_step) |=> (state_q == phd_pkg::MOD_DONE))
    else $error("phd_mod_unit: iteration did not finish");

  // Fan-out frames carry hash zero and therefore index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fanout_q) |-> (hash_q == '0 && rem_q == '0))
    else $error("phd_mod_unit: fan-out result not zero");

endmodule

// ===== sv/packet_header_hash_distributor_unit.sv =====
// Each frame byte is taken while the input is not stalled; after the last byte
// the modulo unit steps through the dividend bits, one at a time, and the result
// then enters the output register once that register is free. Input is stalled
// from the last byte until the result has moved to the output register.
// Reset clears the parser state, the modulo sequencer and the output valid,
// and sets hash_mode to 0 and the destination count to 1.
`timescale 1ns / 1ps

module packet_header_hash_distributor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [phd_pkg::SLV_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [phd_pkg::HASH_W-1:0] hash_value_o,
  output logic [phd_pkg::IDX_W-1:0]  dest_index_o,
  output logic [phd_pkg::HASH_W-1:0] dest_mask_o
);

  phd_pkg::phd_mode_e         mode_q;
  logic [phd_pkg::SLV_W-1:0]  slaves_q;
  phd_pkg::phd_frame_t        frame;
  phd_pkg::phd_result_t       result;
  logic                       mod_busy;
  logic                       mod_done;
  logic                       in_accept;
  logic                       out_free;
  logic                       out_valid_q;
  phd_pkg::phd_result_t       out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= phd_pkg::MODE_IP;
      slaves_q <= phd_pkg::SLV_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        phd_pkg::CFG_HASH_MODE:  mode_q   <= phd_pkg::phd_mode_e'(cfg_wdata_i[1:0]);
        phd_pkg::CFG_DEST_COUNT: slaves_q <= cfg_wdata_i;
        default:                 mode_q   <= mode_q;
      endcase
    end
  end

  // Handshake: items are held off while the modulo unit owns a frame.
  assign in_stall_o = mod_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  phd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .mode_i       (mode_q),
    .dest_count_i (slaves_q),
    .frame_o      (frame)
  );

  phd_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame),
    .release_i (out_free),
    .busy_o    (mod_busy),
    .done_o    (mod_done),
    .result_o  (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= mod_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && mod_done) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q.hash;
  assign dest_index_o = out_q.idx;
  assign dest_mask_o  = out_q.mask;

endmodule
